@@ rtl/coap_retransmit_table_core_defines.svh @@
// assertion macros shared by the checker
`ifndef COAP_RETRANSMIT_TABLE_CORE_DEFINES_SVH
`define COAP_RETRANSMIT_TABLE_CORE_DEFINES_SVH

// immediate implication checked on every clock edge outside reset
`define CRT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/coap_rt_pkg.sv @@
package coap_rt_pkg;

   localparam int DEF_ENTRIES = 8;
   localparam int SLOT_W      = 3;
   localparam int ID_W        = 16;
   localparam int CNT_W       = 3;
   localparam int TMO_W       = 24;
   localparam int MAX_OUT     = 8;
   localparam int NRES_W      = 4;

   localparam logic [15:0]      DEF_BASE_TIMEOUT   = 16'd2000;
   localparam logic [15:0]      DEF_BACKOFF_RANGE  = 16'd1000;
   localparam logic [CNT_W-1:0] DEF_MAX_RETRANSMIT = 3'd4;
   localparam logic [TMO_W-1:0] TMO_MAX            = 24'hFF_FFFF;
   localparam logic [TMO_W-1:0] TMO_HALF           = 24'h7F_FFFF;
   localparam logic [CNT_W-1:0] CNT_SAT            = 3'd7;

   typedef enum logic [1:0] {
      CSR_BASE_TIMEOUT   = 2'd0,
      CSR_BACKOFF_RANGE  = 2'd1,
      CSR_MAX_RETRANSMIT = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      OP_OPEN   = 3'd0,
      OP_SEND   = 3'd1,
      OP_CLEAR  = 3'd2,
      OP_LOOKUP = 3'd3,
      OP_TICK   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      KIND_DONE      = 3'd0,
      KIND_TRANSMIT  = 3'd1,
      KIND_GAVE_UP   = 3'd2,
      KIND_FULL      = 3'd3,
      KIND_NOT_FOUND = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OPEN,
      ST_SEND,
      ST_MOD,
      ST_LOOK,
      ST_TICK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      kind_type          kind;
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   msg_id;
      logic              reliable;
      logic [CNT_W-1:0]  attempt;
      logic              last;
   } result_type;

   localparam result_type RESULT_ZERO = '{kind: KIND_DONE, slot: '0, msg_id: '0,
                                          reliable: 1'b0, attempt: '0, last: 1'b0};

   function automatic logic [TMO_W-1:0] double_tmo(input logic [TMO_W-1:0] t);
      double_tmo = (t > TMO_HALF) ? TMO_MAX : {t[TMO_W-2:0], 1'b0};
   endfunction

endpackage

@@ rtl/coap_rt_mod.sv @@
module coap_rt_mod import coap_rt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] rem
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] dvd_ff, dvd_in;
   logic [15:0] rem_ff, rem_in;
   logic [16:0] trial;
   logic [16:0] diff;

   // restoring remainder, one dividend bit a cycle
   always_comb begin
      trial   = {rem_ff, dvd_ff[15]};
      diff    = trial - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, divisor}) ? diff[15:0] : trial[15:0];
         dvd_in = {dvd_ff[14:0], 1'b0};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

@@ rtl/coap_retransmit_table_core.sv @@
// open and clear/send pass their own state, then the flush state; a first confirmable
// send also waits for the serial remainder unit; lookup and tick scan every slot first
// throughput: one word at a time; next word accepted once the final result is registered
// tick scans one slot per cycle and waits while an earlier expiry result is not taken
// reset: synchronous, clears all slot valid bits and loads the default register values
module coap_retransmit_table_core import coap_rt_pkg::*; #(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_op,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [ID_W-1:0]   req_msg_id,
   input  logic              req_confirmable,
   input  logic [15:0]       req_random_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_kind,
   output logic [SLOT_W-1:0] rsp_out_slot,
   output logic [ID_W-1:0]   rsp_out_msg_id,
   output logic              rsp_reliable,
   output logic [CNT_W-1:0]  rsp_attempt,
   output logic              rsp_last
);

   localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int XW = SW + SLOT_W;
   localparam logic [SW-1:0] LAST_IDX = SW'(ENTRIES - 1);

   // configuration
   logic [15:0]      base_ff, range_ff;
   logic [CNT_W-1:0] maxr_ff;

   // sequencer and item registers
   state_type         state_ff, state_in;
   logic [2:0]        op_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [ID_W-1:0]   mid_ff;
   logic              con_ff;
   logic [15:0]       rnd_ff;
   logic [SW-1:0]     idx_ff, idx_in;
   result_type        hold_ff, hold_in;
   logic              hold_vld_ff, hold_vld_in;
   logic [NRES_W-1:0] nres_ff, nres_in;
   logic              hit_ff, hit_in;
   logic [SW-1:0]     best_ff, best_in;
   logic [SW-1:0]     brank_ff, brank_in;

   // slot table
   logic              valid_ff [ENTRIES];
   logic [ID_W-1:0]   id_ff    [ENTRIES];
   logic [CNT_W-1:0]  rc_ff    [ENTRIES];
   logic [TMO_W-1:0]  tmo_ff   [ENTRIES];
   logic [TMO_W-1:0]  tl_ff    [ENTRIES];
   logic [SW-1:0]     rank_ff  [ENTRIES];

   // result register
   logic              rsp_vld_ff, rsp_vld_in;
   result_type        rsp_ff, rsp_in;

   // control from the sequencer
   logic do_accept, do_open, do_send, do_mod_fin, do_look, do_tick, do_flush;
   logic mod_start, push_ok, tick_wait;

   // table write requests
   logic              open_en, free_en, arm_en, rc_en, dec_en;
   logic [SW-1:0]     open_sel, free_sel, arm_sel, rc_sel;
   logic [TMO_W-1:0]  arm_tmo;
   logic [CNT_W-1:0]  rc_val;

   // helpers
   logic [XW-1:0]     slot_wide;
   logic              slot_ok;
   logic [SW-1:0]     sidx;
   logic              free_found;
   logic [SW-1:0]     free_idx;
   logic [XW-1:0]     free_wide, idx_wide, best_wide;
   logic              tk_live, tk_expire;
   logic [CNT_W-1:0]  rc_inc;
   logic              lk_take;
   logic              mod_done;
   logic [15:0]       mod_rem;
   logic [TMO_W-1:0]  first_tmo;

   coap_rt_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (rnd_ff),
      .divisor  (range_ff),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   always_comb begin
      slot_wide = XW'(slot_ff);
      slot_ok   = slot_wide < XW'(ENTRIES);
      sidx      = slot_wide[SW-1:0];
      idx_wide  = XW'(idx_ff);
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
      end
      free_wide = XW'(free_idx);
      tk_live   = valid_ff[idx_ff] && (tl_ff[idx_ff] != '0);
      tk_expire = tk_live && (tl_ff[idx_ff] == TMO_W'(1)) && (nres_ff < NRES_W'(MAX_OUT));
      rc_inc    = (rc_ff[idx_ff] == CNT_SAT) ? CNT_SAT : rc_ff[idx_ff] + 3'd1;
      lk_take   = valid_ff[idx_ff] && (id_ff[idx_ff] == mid_ff) &&
                  (!hit_ff || (rank_ff[idx_ff] < brank_ff));
      first_tmo = TMO_W'(base_ff) + TMO_W'((range_ff == '0) ? 16'd0 : mod_rem);
      push_ok   = !rsp_vld_ff || !rsp_stall;
      tick_wait = tk_expire && hold_vld_ff && !push_ok;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_OPEN:              state_in = ST_OPEN;
                  OP_SEND, OP_CLEAR:    state_in = ST_SEND;
                  OP_LOOKUP:            state_in = ST_LOOK;
                  OP_TICK:              state_in = ST_TICK;
                  default:              state_in = ST_FLUSH;
               endcase
            end
         end
         ST_OPEN:  state_in = ST_FLUSH;
         ST_SEND: begin
            if (slot_ok && valid_ff[sidx] && (op_ff == OP_SEND) && con_ff &&
                (rc_ff[sidx] < maxr_ff) && (rc_ff[sidx] == '0))
               state_in = ST_MOD;
            else
               state_in = ST_FLUSH;
         end
         ST_MOD:   if (mod_done) state_in = ST_FLUSH;
         ST_LOOK:  if (idx_ff == LAST_IDX) state_in = ST_FLUSH;
         ST_TICK:  if (!tick_wait && (idx_ff == LAST_IDX)) state_in = ST_FLUSH;
         ST_FLUSH: if (push_ok) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall  = 1'b1;
      do_accept  = 1'b0;
      do_open    = 1'b0;
      do_send    = 1'b0;
      mod_start  = 1'b0;
      do_mod_fin = 1'b0;
      do_look    = 1'b0;
      do_tick    = 1'b0;
      do_flush   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            do_accept = req_valid;
         end
         ST_OPEN:  do_open = 1'b1;
         ST_SEND: begin
            do_send   = 1'b1;
            mod_start = slot_ok && valid_ff[sidx] && (op_ff == OP_SEND) && con_ff &&
                        (rc_ff[sidx] < maxr_ff) && (rc_ff[sidx] == '0);
         end
         ST_MOD:   do_mod_fin = mod_done;
         ST_LOOK:  do_look = 1'b1;
         ST_TICK:  do_tick = !tick_wait;
         ST_FLUSH: do_flush = push_ok;
         default:  req_stall = 1'b1;
      endcase
   end

   // datapath
   always_comb begin
      idx_in      = idx_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      nres_in     = nres_ff;
      hit_in      = hit_ff;
      best_in     = best_ff;
      brank_in    = brank_ff;
      rsp_vld_in  = rsp_vld_ff && rsp_stall;
      rsp_in      = rsp_ff;
      open_en  = 1'b0;
      open_sel = free_idx;
      free_en  = 1'b0;
      free_sel = sidx;
      arm_en   = 1'b0;
      arm_sel  = sidx;
      arm_tmo  = double_tmo(tmo_ff[sidx]);
      rc_en    = 1'b0;
      rc_sel   = idx_ff;
      rc_val   = rc_inc;
      dec_en   = 1'b0;
      best_wide = '0;

      if (do_accept) begin
         idx_in      = '0;
         hold_vld_in = 1'b0;
         nres_in     = '0;
         hit_in      = 1'b0;
      end

      if (do_open) begin
         hold_vld_in = 1'b1;
         if (free_found) begin
            open_en = 1'b1;
            hold_in = '{kind: KIND_DONE, slot: free_wide[SLOT_W-1:0], msg_id: mid_ff,
                        reliable: 1'b0, attempt: '0, last: 1'b0};
         end else begin
            hold_in = '{kind: KIND_FULL, slot: '0, msg_id: mid_ff,
                        reliable: 1'b0, attempt: '0, last: 1'b0};
         end
      end

      if (do_send) begin
         hold_vld_in = 1'b1;
         if (!slot_ok || !valid_ff[sidx]) begin
            hold_in = '{kind: KIND_NOT_FOUND, slot: slot_ff, msg_id: '0,
                        reliable: 1'b0, attempt: '0, last: 1'b0};
         end else if (op_ff == OP_CLEAR) begin
            free_en = 1'b1;
            hold_in = '{kind: KIND_DONE, slot: slot_ff, msg_id: id_ff[sidx],
                        reliable: 1'b0, attempt: '0, last: 1'b0};
         end else if (!con_ff) begin
            free_en = 1'b1;
            hold_in = '{kind: KIND_TRANSMIT, slot: slot_ff, msg_id: id_ff[sidx],
                        reliable: 1'b0, attempt: rc_ff[sidx], last: 1'b0};
         end else if (rc_ff[sidx] < maxr_ff) begin
            // first send arms after the remainder unit finishes
            arm_en  = (rc_ff[sidx] != '0);
            hold_in = '{kind: KIND_TRANSMIT, slot: slot_ff, msg_id: id_ff[sidx],
                        reliable: 1'b1, attempt: rc_ff[sidx], last: 1'b0};
         end else begin
            free_en = 1'b1;
            hold_in = '{kind: KIND_GAVE_UP, slot: slot_ff, msg_id: id_ff[sidx],
                        reliable: 1'b0, attempt: rc_ff[sidx], last: 1'b0};
         end
      end

      if (do_mod_fin) begin
         arm_en  = 1'b1;
         arm_tmo = first_tmo;
      end

      if (do_look) begin
         if (lk_take) begin
            hit_in   = 1'b1;
            best_in  = idx_ff;
            brank_in = rank_ff[idx_ff];
         end
         if (idx_ff == LAST_IDX) begin
            hold_vld_in = 1'b1;
            if (lk_take || hit_ff) begin
               best_wide = XW'(lk_take ? idx_ff : best_ff);
               hold_in = '{kind: KIND_DONE, slot: best_wide[SLOT_W-1:0], msg_id: mid_ff,
                           reliable: 1'b0, attempt: '0, last: 1'b0};
            end else begin
               hold_in = '{kind: KIND_NOT_FOUND, slot: '0, msg_id: mid_ff,
                           reliable: 1'b0, attempt: '0, last: 1'b0};
            end
         end else begin
            idx_in = idx_ff + SW'(1);
         end
      end

      if (do_tick) begin
         if (tk_expire) begin
            if (hold_vld_ff) begin
               rsp_vld_in = 1'b1;
               rsp_in     = hold_ff;
            end
            rc_en       = 1'b1;
            nres_in     = nres_ff + NRES_W'(1);
            hold_vld_in = 1'b1;
            if (rc_inc < maxr_ff) begin
               arm_en  = 1'b1;
               arm_sel = idx_ff;
               arm_tmo = double_tmo(tmo_ff[idx_ff]);
               hold_in = '{kind: KIND_TRANSMIT, slot: idx_wide[SLOT_W-1:0],
                           msg_id: id_ff[idx_ff], reliable: 1'b1, attempt: rc_inc,
                           last: 1'b0};
            end else begin
               free_en  = 1'b1;
               free_sel = idx_ff;
               hold_in  = '{kind: KIND_GAVE_UP, slot: idx_wide[SLOT_W-1:0],
                            msg_id: id_ff[idx_ff], reliable: 1'b0, attempt: rc_inc,
                            last: 1'b0};
            end
         end else if (tk_live && (tl_ff[idx_ff] != TMO_W'(1))) begin
            dec_en = 1'b1;
         end
         if (idx_ff != LAST_IDX) idx_in = idx_ff + SW'(1);
      end

      if (do_flush) begin
         rsp_vld_in  = 1'b1;
         rsp_in      = hold_vld_ff ? hold_ff : RESULT_ZERO;
         rsp_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
         base_ff    <= DEF_BASE_TIMEOUT;
         range_ff   <= DEF_BACKOFF_RANGE;
         maxr_ff    <= DEF_MAX_RETRANSMIT;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BASE_TIMEOUT:   base_ff  <= csr_wdata;
               CSR_BACKOFF_RANGE:  range_ff <= csr_wdata;
               CSR_MAX_RETRANSMIT: maxr_ff  <= csr_wdata[CNT_W-1:0];
               default:            maxr_ff  <= maxr_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_accept) begin
         op_ff   <= req_op;
         slot_ff <= req_slot;
         mid_ff  <= req_msg_id;
         con_ff  <= req_confirmable;
         rnd_ff  <= req_random_value;
      end
      idx_ff      <= idx_in;
      hold_ff     <= hold_in;
      hold_vld_ff <= hold_vld_in;
      nres_ff     <= nres_in;
      hit_ff      <= hit_in;
      best_ff     <= best_in;
      brank_ff    <= brank_in;
      rsp_ff      <= rsp_in;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ENTRIES; j++) valid_ff[j] <= 1'b0;
      end else begin
         if (open_en) valid_ff[open_sel] <= 1'b1;
         if (free_en) valid_ff[free_sel] <= 1'b0;
      end
   end

   // slot contents; rank 0 is the newest open entry
   always_ff @(posedge clock) begin
      for (int j = 0; j < ENTRIES; j++) begin
         if (open_en) begin
            if (SW'(j) == open_sel) begin
               id_ff[j]   <= mid_ff;
               rc_ff[j]   <= '0;
               tl_ff[j]   <= '0;
               rank_ff[j] <= '0;
            end else if (valid_ff[j]) begin
               rank_ff[j] <= rank_ff[j] + SW'(1);
            end
         end
         if (free_en) begin
            if (SW'(j) == free_sel) begin
               tl_ff[j] <= '0;
            end else if (valid_ff[j] && (rank_ff[j] > rank_ff[free_sel])) begin
               rank_ff[j] <= rank_ff[j] - SW'(1);
            end
         end
         if (arm_en && (SW'(j) == arm_sel)) begin
            tmo_ff[j] <= arm_tmo;
            tl_ff[j]  <= (arm_tmo != '0) ? arm_tmo : TMO_W'(1);
         end
         if (rc_en && (SW'(j) == rc_sel)) rc_ff[j] <= rc_val;
         if (dec_en && (SW'(j) == idx_ff)) tl_ff[j] <= tl_ff[j] - TMO_W'(1);
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_out_slot   = rsp_ff.slot;
   assign rsp_out_msg_id = rsp_ff.msg_id;
   assign rsp_reliable   = rsp_ff.reliable;
   assign rsp_attempt    = rsp_ff.attempt;
   assign rsp_last       = rsp_ff.last;

endmodule

@@ rtl/coap_rt_checker.sv @@
`include "coap_retransmit_table_core_defines.svh"

module coap_rt_checker import coap_rt_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [2:0]        rsp_kind,
   input logic              rsp_reliable,
   input logic [CNT_W-1:0]  rsp_attempt,
   input logic              rsp_last
);

   `CRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind),
      "stalled result word dropped or changed")

   `CRT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
      "input word taken while previous word still in work")

   `CRT_ASSERT_NOW(a_reliable_kind, rsp_valid && rsp_reliable, rsp_kind == KIND_TRANSMIT,
      "reliable flag on a result that is not a transmit")

   `CRT_ASSERT_NOW(a_not_found_clean, rsp_valid && (rsp_kind == KIND_NOT_FOUND),
      (rsp_attempt == '0) && !rsp_reliable && rsp_last,
      "not found result carries retry data or is not final")

endmodule

bind coap_retransmit_table_core coap_rt_checker u_coap_rt_checker (.*);

@@ tb/sv/coap_retransmit_table_core_tb.sv @@
module coap_retransmit_table_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import coap_rt_pkg::*;

   localparam int NSLOT = 8;

   typedef struct packed {
      logic [2:0]  op;
      logic [2:0]  slot;
      logic [15:0] msg_id;
      logic        confirmable;
      logic [15:0] random_value;
   } word_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  slot;
      logic [15:0] msg_id;
      logic        reliable;
      logic [2:0]  attempt;
      logic        last;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = '0;
   logic [2:0]  req_slot = '0;
   logic [15:0] req_msg_id = '0;
   logic        req_confirmable = 1'b0;
   logic [15:0] req_random_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [2:0]  rsp_out_slot;
   logic [15:0] rsp_out_msg_id;
   logic        rsp_reliable;
   logic [2:0]  rsp_attempt;
   logic        rsp_last;

   coap_retransmit_table_core DUT (.*);

   // shadow of the slot table and registers
   logic [15:0] base_tmo, spread, id_tbl[NSLOT];
   logic [2:0]  retry_lim, tries[NSLOT], age[NSLOT];
   logic [23:0] tmo[NSLOT], left[NSLOT];
   logic        busy[NSLOT];

   word_type   pending_words[$];
   answer_type expected_answers[$];
   int errors = 0, cycles = 0;
   bit hold_go = 1'b0;
   bit holding = 1'b0;
   int send_gap = 0, rsp_gap = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic push_answer(input int k, input int s, input int id, input int r,
                              input int a);
      answer_type x;
      x = '{kind: 3'(k), slot: 3'(s), msg_id: 16'(id), reliable: 1'(r), attempt: 3'(a),
            last: 1'b0};
      expected_answers.push_back(x);
   endtask

   task automatic release_slot(input int s);
      for (int i = 0; i < NSLOT; i++)
         if (busy[i] && i != s && age[i] > age[s]) age[i]--;
      busy[s] = 0;
      left[s] = '0;
   endtask

   task automatic transmit(input int s, input logic con, input logic [15:0] rnd);
      logic [23:0] t;
      if (!con) begin
         push_answer(KIND_TRANSMIT, s, id_tbl[s], 0, tries[s]);
         release_slot(s);
      end else if (tries[s] < retry_lim) begin
         if (tries[s] == 0) t = base_tmo + (spread != 0 ? rnd % spread : 16'd0);
         else t = (tmo[s] > TMO_HALF) ? TMO_MAX : {tmo[s][22:0], 1'b0};
         tmo[s] = t;
         left[s] = (t != 0) ? t : 24'd1;
         push_answer(KIND_TRANSMIT, s, id_tbl[s], 1, tries[s]);
      end else begin
         push_answer(KIND_GAVE_UP, s, id_tbl[s], 0, tries[s]);
         release_slot(s);
      end
   endtask

   task automatic predict_word(input word_type w);
      int i, n0, best;
      bit hit;
      n0 = expected_answers.size();
      case (w.op)
         OP_OPEN: begin
            for (i = 0; i < NSLOT && busy[i]; i++) ;
            if (i >= NSLOT) push_answer(KIND_FULL, 0, w.msg_id, 0, 0);
            else begin
               for (int j = 0; j < NSLOT; j++) if (busy[j]) age[j]++;
               busy[i] = 1; id_tbl[i] = w.msg_id; tries[i] = 0;
               left[i] = 0; age[i] = 0;
               push_answer(KIND_DONE, i, w.msg_id, 0, 0);
            end
         end
         OP_SEND, OP_CLEAR: begin
            if (!busy[w.slot]) push_answer(KIND_NOT_FOUND, w.slot, 0, 0, 0);
            else if (w.op == OP_SEND) transmit(w.slot, w.confirmable, w.random_value);
            else begin
               push_answer(KIND_DONE, w.slot, id_tbl[w.slot], 0, 0);
               release_slot(w.slot);
            end
         end
         OP_LOOKUP: begin
            hit = 0; best = 0;
            for (i = 0; i < NSLOT; i++)
               if (busy[i] && id_tbl[i] == w.msg_id && (!hit || age[i] < age[best])) begin
                  hit = 1; best = i;
               end
            if (hit) push_answer(KIND_DONE, best, w.msg_id, 0, 0);
            else push_answer(KIND_NOT_FOUND, 0, w.msg_id, 0, 0);
         end
         OP_TICK: begin
            for (i = 0; i < NSLOT; i++) begin
               if (!busy[i] || left[i] == 0) continue;
               if (left[i] == 1) begin
                  left[i] = 0;
                  if (tries[i] < CNT_SAT) tries[i]++;
                  transmit(i, 1'b1, w.random_value);
               end else left[i]--;
            end
            if (expected_answers.size() == n0) push_answer(KIND_DONE, 0, 0, 0, 0);
         end
         default: push_answer(KIND_DONE, 0, 0, 0, 0);
      endcase
      expected_answers[expected_answers.size()-1].last = 1'b1;
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_word({req_op, req_slot, req_msg_id, req_confirmable, req_random_value});
            req_valid <= 1'b0;
            send_gap = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
         end else if (!req_valid) begin
            if (send_gap > 0) send_gap--;
            else if (pending_words.size() > 0) begin
               word_type w;
               w = pending_words.pop_front();
               req_op <= w.op; req_slot <= w.slot; req_msg_id <= w.msg_id;
               req_confirmable <= w.confirmable; req_random_value <= w.random_value;
               req_valid <= 1'b1;
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            answer_type got, exp_a;
            got = {rsp_kind, rsp_out_slot, rsp_out_msg_id, rsp_reliable, rsp_attempt, rsp_last};
            if (expected_answers.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result %h", got);
            end else begin
               exp_a = expected_answers.pop_front();
               if (got !== exp_a) begin
                  errors++;
                  if (errors <= 10) $display("mismatch exp %h got %h", exp_a, got);
               end
            end
            rsp_gap = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) rsp_gap = 0;
         end
         if (holding) begin
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else rsp_stall <= 1'b0;
      end
   end

   // long receiver hold-off while the sender keeps offering words
   initial begin
      wait (hold_go);
      holding = 1'b1;
      repeat (300) @(posedge clock);
      holding = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 2000000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic word_type mk(input int op, input int s, input int id, input int c,
                                   input int r);
      mk = '{op: 3'(op), slot: 3'(s), msg_id: 16'(id), confirmable: 1'(c),
             random_value: 16'(r)};
   endfunction

   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input csr_type idx, input logic [15:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wdata <= v;
      case (idx)
         CSR_BASE_TIMEOUT:  base_tmo = v;
         CSR_BACKOFF_RANGE: spread = v;
         default:           retry_lim = v[2:0];
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      int p;
      word_type w;
      for (int k = 0; k < count; k++) begin
         w = mk($urandom_range(0, 4), $urandom_range(0, 7), $urandom_range(0, 3),
                int'($urandom_range(0, 3) != 0), $urandom());
         p = $urandom_range(0, 99);
         if (p < 3) w.op = 3'($urandom_range(5, 7));
         else if (p < 8) w.msg_id = 16'($urandom());
         else if (p < 38) w.op = OP_TICK;
         pending_words.push_back(w);
      end
   endtask

   initial begin
      base_tmo = DEF_BASE_TIMEOUT; spread = DEF_BACKOFF_RANGE; retry_lim = DEF_MAX_RETRANSMIT;
      for (int i = 0; i < NSLOT; i++) begin
         busy[i] = 0; left[i] = 0; id_tbl[i] = 0; tries[i] = 0; tmo[i] = 0; age[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // short timers so expiries come quickly
      write_reg(CSR_BASE_TIMEOUT, 16'd0);
      write_reg(CSR_BACKOFF_RANGE, 16'd0);
      write_reg(CSR_MAX_RETRANSMIT, 3'd7);
      pending_words.push_back(mk(OP_SEND, 3'd7, 16'hFFFF, 1, 16'hFFFF));
      pending_words.push_back(mk(OP_CLEAR, 3'd0, 16'h0, 0, 16'h0));
      pending_words.push_back(mk(OP_LOOKUP, 3'd0, 16'h1234, 0, 16'h0));
      for (int i = 0; i < 9; i++)
         pending_words.push_back(mk(OP_OPEN, 3'd0, (i == 8) ? 16'hFFFF : 16'hA5A5, 0, 0));
      pending_words.push_back(mk(OP_LOOKUP, 3'd0, 16'hA5A5, 0, 0));
      pending_words.push_back(mk(OP_SEND, 3'd0, 0, 1, 16'hFFFF));
      pending_words.push_back(mk(OP_SEND, 3'd1, 0, 0, 0));
      pending_words.push_back(mk(OP_CLEAR, 3'd2, 0, 0, 0));
      for (int i = 3; i < 8; i++) pending_words.push_back(mk(OP_SEND, i, 0, 1, i));
      pending_words.push_back(mk(OP_TICK, 0, 0, 0, 16'hFFFF));
      pending_words.push_back(mk(OP_TICK, 0, 0, 0, 0));
      pending_words.push_back(mk(3'd7, 3'd7, 16'hFFFF, 1, 16'hFFFF));
      drain();
      write_reg(CSR_BASE_TIMEOUT, 16'd3);
      write_reg(CSR_BACKOFF_RANGE, 16'd4);
      write_reg(CSR_MAX_RETRANSMIT, 3'd0);
      random_phase(60);
      drain();
      write_reg(CSR_MAX_RETRANSMIT, 3'd5);
      write_reg(CSR_BACKOFF_RANGE, 16'd1);
      hold_go = 1'b1;
      random_phase(100);
      drain();
      write_reg(CSR_BASE_TIMEOUT, 16'hFFFF);
      write_reg(CSR_BACKOFF_RANGE, 16'hFFFF);
      write_reg(CSR_MAX_RETRANSMIT, 3'd7);
      random_phase(30);
      drain();
      write_reg(CSR_BASE_TIMEOUT, 16'd1);
      write_reg(CSR_BACKOFF_RANGE, 16'd2);
      write_reg(CSR_MAX_RETRANSMIT, 3'd3);
      random_phase(110);
      drain();
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/coap_rt_pkg.sv
rtl/coap_rt_mod.sv
rtl/coap_retransmit_table_core.sv
rtl/coap_rt_checker.sv
tb/sv/coap_retransmit_table_core_tb.sv
